// File: rtl/core/amrt_pkg.sv
package amrt_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // field widths fixed by the interface
   localparam int FILL_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [FILL_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic [7:0]        SEND_TTL_RESET = 8'd30;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_TTL = 2'd1;

   // request modes
   localparam logic [2:0] MODE_INSERT     = 3'd0;
   localparam logic [2:0] MODE_ACK_REMOVE = 3'd1;
   localparam logic [2:0] MODE_TICK       = 3'd2;
   localparam logic [2:0] MODE_REMOVE     = 3'd3;
   localparam logic [2:0] MODE_READ       = 3'd4;

   // response status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_MISS  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] seq_bytes;
      logic [31:0] payload_ref;
      logic        send_kind;
      logic [3:0]  slot;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [FILL_W-1:0] fill_count;
      logic [31:0]       out_ip;
      logic [15:0]       out_port;
      logic [31:0]       out_seq;
      logic [31:0]       out_ref;
      logic [7:0]        out_ttl;
   } rsp_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_SLOT,
      PTR_SLOT_NEXT,
      PTR_NEXT
   } ptr_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_INSERT,
      WR_SHIFT,
      WR_TICK
   } wr_op_type;

   typedef enum logic [1:0] {
      TOT_HOLD,
      TOT_INC,
      TOT_DEC
   } tot_op_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      ptr_op_type ptr_op;
      wr_op_type  wr_op;
      tot_op_type tot_op;
      logic       set_status;
      logic [1:0] status_code;
      logic       set_read;
      logic       set_ttl;
      logic       rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] mode;
      logic       can_insert;
      logic       total_zero;
      logic       slot_ok;
      logic       match;
      logic       ptr_last;
      logic       ptr_end;
      logic       ttl_zero;
      logic       ttl_one;
      logic       rsp_free;
   } stat_type;

endpackage

// File: rtl/core/amrt_ctrl.sv
module amrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  amrt_pkg::stat_type stat,
   output amrt_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_CHECK,
      ST_SHIFT,
      ST_REPLY
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.ptr_op = amrt_pkg::PTR_HOLD;
      cmd.wr_op = amrt_pkg::WR_NONE;
      cmd.tot_op = amrt_pkg::TOT_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.set_status = 1'b1;
            cmd.status_code = amrt_pkg::STATUS_DONE;
            state_in = ST_REPLY;
            unique case (stat.mode)
               amrt_pkg::MODE_INSERT: begin
                  if (stat.can_insert) begin
                     cmd.wr_op = amrt_pkg::WR_INSERT;
                     cmd.tot_op = amrt_pkg::TOT_INC;
                  end else begin
                     cmd.status_code = amrt_pkg::STATUS_MISS;
                  end
               end
               amrt_pkg::MODE_ACK_REMOVE: begin
                  if (stat.total_zero) begin
                     cmd.status_code = amrt_pkg::STATUS_MISS;
                  end else begin
                     cmd.ptr_op = amrt_pkg::PTR_ZERO;
                     state_in = ST_SCAN;
                  end
               end
               amrt_pkg::MODE_TICK: begin
                  if (!stat.slot_ok) begin
                     cmd.status_code = amrt_pkg::STATUS_RANGE;
                  end else begin
                     cmd.ptr_op = amrt_pkg::PTR_SLOT;
                     state_in = ST_CHECK;
                  end
               end
               amrt_pkg::MODE_REMOVE: begin
                  if (!stat.slot_ok) begin
                     cmd.status_code = amrt_pkg::STATUS_RANGE;
                  end else begin
                     // compaction reads one past the removed entry
                     cmd.ptr_op = amrt_pkg::PTR_SLOT_NEXT;
                     state_in = ST_SHIFT;
                  end
               end
               amrt_pkg::MODE_READ: begin
                  if (!stat.slot_ok) begin
                     cmd.status_code = amrt_pkg::STATUS_RANGE;
                  end else begin
                     cmd.ptr_op = amrt_pkg::PTR_SLOT;
                     cmd.set_read = 1'b1;
                  end
               end
               default: begin
                  cmd.status_code = amrt_pkg::STATUS_MISS;
               end
            endcase
         end
         ST_SCAN: begin
            if (stat.match) begin
               cmd.ptr_op = amrt_pkg::PTR_NEXT;
               state_in = ST_SHIFT;
            end else if (stat.ptr_last) begin
               cmd.set_status = 1'b1;
               cmd.status_code = amrt_pkg::STATUS_MISS;
               state_in = ST_REPLY;
            end else begin
               cmd.ptr_op = amrt_pkg::PTR_NEXT;
            end
         end
         ST_CHECK: begin
            // ttl already zero: entry stays, reported ttl stays zero
            if (!stat.ttl_zero) begin
               cmd.wr_op = amrt_pkg::WR_TICK;
               cmd.set_ttl = 1'b1;
               if (stat.ttl_one) begin
                  cmd.ptr_op = amrt_pkg::PTR_NEXT;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_REPLY;
               end
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_SHIFT: begin
            if (stat.ptr_end) begin
               cmd.tot_op = amrt_pkg::TOT_DEC;
               state_in = ST_REPLY;
            end else begin
               cmd.wr_op = amrt_pkg::WR_SHIFT;
               cmd.ptr_op = amrt_pkg::PTR_NEXT;
            end
         end
         ST_REPLY: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/amrt_dp.sv
module amrt_dp #(
   parameter int DEPTH = amrt_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  amrt_pkg::req_type                  req_data,
   input  amrt_pkg::cmd_type                  cmd,
   output amrt_pkg::stat_type                 stat,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output amrt_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   input  logic [amrt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [amrt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW_DEPTH = $clog2(DEPTH + 1);
   localparam int CUR_W = (CW_DEPTH > amrt_pkg::FILL_W) ? CW_DEPTH : amrt_pkg::FILL_W;
   localparam logic [CUR_W-1:0] DEPTH_C = CUR_W'(DEPTH);

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] seq;
      logic [31:0] ref_id;
      logic [7:0]  ttl;
   } entry_type;

   entry_type mem [DEPTH];
   entry_type rdata_ff;
   entry_type wdata;
   logic [IW-1:0] waddr;
   logic          wen;

   amrt_pkg::req_type req_ff;

   logic [amrt_pkg::FILL_W-1:0] total_ff;
   logic [amrt_pkg::FILL_W-1:0] total_in;
   logic [amrt_pkg::FILL_W-1:0] capacity_ff;
   logic [7:0]                  send_ttl_ff;

   logic [CUR_W-1:0] ptr_ff;
   logic [CUR_W-1:0] ptr_in;
   logic [CUR_W-1:0] ptr_prev;
   logic [CUR_W-1:0] total_ext;
   logic [CUR_W-1:0] slot_ext;
   logic [CUR_W-1:0] cap_ext;

   logic [1:0] res_status_ff;
   logic       res_read_ff;
   logic [7:0] res_ttl_ff;

   logic              rsp_valid_ff;
   amrt_pkg::rsp_type rsp_data_ff;

   assign total_ext = CUR_W'(total_ff);
   assign slot_ext  = CUR_W'(req_ff.slot);
   assign cap_ext   = CUR_W'(capacity_ff);
   assign ptr_prev  = ptr_ff - CUR_W'(1);

   always_comb begin
      case (cmd.ptr_op)
         amrt_pkg::PTR_ZERO:      ptr_in = '0;
         amrt_pkg::PTR_SLOT:      ptr_in = slot_ext;
         amrt_pkg::PTR_SLOT_NEXT: ptr_in = slot_ext + CUR_W'(1);
         amrt_pkg::PTR_NEXT:      ptr_in = ptr_ff + CUR_W'(1);
         default:                 ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      wen = 1'b1;
      waddr = ptr_ff[IW-1:0];
      wdata = rdata_ff;
      case (cmd.wr_op)
         amrt_pkg::WR_INSERT: begin
            waddr = total_ext[IW-1:0];
            wdata.ip = req_ff.peer_ip;
            wdata.port = req_ff.peer_port;
            wdata.seq = req_ff.seq_bytes;
            wdata.ref_id = req_ff.payload_ref;
            wdata.ttl = req_ff.send_kind ? send_ttl_ff : 8'd0;
         end
         amrt_pkg::WR_SHIFT: begin
            // move the entry just read down by one place
            waddr = ptr_prev[IW-1:0];
         end
         amrt_pkg::WR_TICK: begin
            wdata.ttl = rdata_ff.ttl - 8'd1;
         end
         default: begin
            wen = 1'b0;
         end
      endcase
   end

   // read address follows the next pointer so read data lines up with ptr_ff
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[ptr_in[IW-1:0]];
   end

   always_comb begin
      case (cmd.tot_op)
         amrt_pkg::TOT_INC: total_in = total_ff + 5'd1;
         amrt_pkg::TOT_DEC: total_in = total_ff - 5'd1;
         default:           total_in = total_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         capacity_ff <= amrt_pkg::CAPACITY_RESET;
         send_ttl_ff <= amrt_pkg::SEND_TTL_RESET;
         ptr_ff <= '0;
      end else begin
         total_ff <= total_in;
         ptr_ff <= ptr_in;
         if (csr_valid) begin
            unique case (csr_index)
               amrt_pkg::CSR_CAPACITY: capacity_ff <= csr_wdata[amrt_pkg::FILL_W-1:0];
               amrt_pkg::CSR_SEND_TTL: send_ttl_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
         res_read_ff <= 1'b0;
         res_ttl_ff <= '0;
      end else begin
         if (cmd.set_read) begin
            res_read_ff <= 1'b1;
         end
         if (cmd.set_ttl) begin
            res_ttl_ff <= rdata_ff.ttl - 8'd1;
         end
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff.status <= res_status_ff;
         rsp_data_ff.fill_count <= total_ff;
         rsp_data_ff.out_ip <= res_read_ff ? rdata_ff.ip : 32'd0;
         rsp_data_ff.out_port <= res_read_ff ? rdata_ff.port : 16'd0;
         rsp_data_ff.out_seq <= res_read_ff ? rdata_ff.seq : 32'd0;
         rsp_data_ff.out_ref <= res_read_ff ? rdata_ff.ref_id : 32'd0;
         rsp_data_ff.out_ttl <= res_read_ff ? rdata_ff.ttl : res_ttl_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      stat.mode = req_ff.mode;
      stat.can_insert = (total_ext < cap_ext) && (total_ext < DEPTH_C);
      stat.total_zero = (total_ff == '0);
      stat.slot_ok = (slot_ext < total_ext);
      stat.match = (rdata_ff.seq == req_ff.seq_bytes) && (rdata_ff.ip == req_ff.peer_ip) &&
                   (rdata_ff.port == req_ff.peer_port);
      stat.ptr_last = (ptr_ff == total_ext - CUR_W'(1));
      stat.ptr_end = (ptr_ff == total_ext);
      stat.ttl_zero = (rdata_ff.ttl == 8'd0);
      stat.ttl_one = (rdata_ff.ttl == 8'd1);
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// File: rtl/core/ack_matched_retransmit_table.sv
// Ordered table of pending packets with ACK matching.
// req_* carries one request (insert, remove by ACK, tick ttl, remove at slot,
// read at slot) as a req_type struct; it is taken when req_valid is high and
// req_stall is low. Each request gives exactly one response on rsp_*, taken
// when rsp_valid is high and rsp_stall is low.
// csr_* writes capacity (index 0) and send ttl (index 1); csr_ready is always
// high. The user must make writes only while no request is in flight; the
// block itself does not enforce it. Insert, read, and any refused or out of
// range request go from decode straight to reply; a tick first rewrites the
// entry ttl in a check step unless it is already zero. A removal compacts
// the table one entry per cycle through the memory's single write port:
// remove at slot and a tick that expires its entry move each later entry
// down; an ACK removal first walks the table one entry per cycle to find
// its match, scanning all of it on a miss. One request is worked on at a
// time; the next is taken as soon as the response register is loaded.
// Reset empties the table (fill count 0) and sets capacity 16 and send ttl
// 30; entry storage is not cleared. While rsp_stall holds a response, the
// block can take one more request and finishes it up to its response.
module ack_matched_retransmit_table #(
   parameter int DEPTH = amrt_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  amrt_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output amrt_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [amrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [amrt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   amrt_pkg::cmd_type  cmd;
   amrt_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   amrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   amrt_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // a taken request stalls the request port in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken back to back");

   // table only grows when there is room
   assert property (@(posedge clock) disable iff (reset)
      (cmd.tot_op == amrt_pkg::TOT_INC) |-> stat.can_insert)
      else $error("fill count raised on a full table");

   // fill count never passes the storage depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_data.fill_count) <= DEPTH))
      else $error("fill count beyond depth");

   // a response is only loaded into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

endmodule
